// ===== sv/sll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere lattice level set: shared package
// Types, widths, register indexes and command codes used by the controller,
// the datapath and the top level.
// ----------------------------------------------------------------------------
package sll_pkg;

  // Largest number of spheres along one axis.
  localparam int MAX_SPH = 8;

  // Width of a per-axis sphere count (holds MAX_SPH itself).
  localparam int CNT_W = $clog2(MAX_SPH + 1);
  // Width of a sphere index along one axis.
  localparam int IDX_W = (MAX_SPH > 1) ? $clog2(MAX_SPH) : 1;

  // Product of packing factor and radius, and its running multiple.
  localparam int PROD_W = 62;
  localparam int ACC_W  = PROD_W + CNT_W;

  // Odd multiple of the spacing, and signed distances along one axis.
  localparam int M_W   = 40;
  localparam int MAG_W = 35;

  // Squared distances and the square root.
  localparam int SUM_W      = 72;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;

  // Length magnitude handled by the small divider.
  localparam int DIV_STEPS = 32;

  // Controller step counter.
  localparam int CTR_W = 6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_X  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Y  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Z  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_X = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Y = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Z = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PACK   = 4'd7;

  // Axis codes.
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Partial product selects for the squaring unit.
  localparam logic [1:0] PP_LL = 2'd0;
  localparam logic [1:0] PP_HL = 2'd1;
  localparam logic [1:0] PP_HH = 2'd2;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [31:0] low_x;
    logic signed [31:0] low_y;
    logic signed [31:0] low_z;
    logic signed [31:0] high_x;
    logic signed [31:0] high_y;
    logic signed [31:0] high_z;
    logic [30:0]        radius;
    logic [30:0]        pack;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_pt;
    logic             prod;
    logic             best_init;
    logic             axis_init;
    logic             cnt_step;
    logic             div_init;
    logic             div_step;
    logic             sp_latch;
    logic             sq_load;
    logic             sq_pp;
    logic             sq_store;
    logic             visit;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             out_fire;
    logic [1:0]       axis;
    logic [IDX_W-1:0] idx;
    logic [1:0]       pp_sel;
    logic [IDX_W-1:0] vi;
    logic [IDX_W-1:0] vj;
    logic [IDX_W-1:0] vk;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] n_cur;
    logic [CNT_W-1:0] cnt_x;
    logic [CNT_W-1:0] cnt_y;
    logic [CNT_W-1:0] cnt_z;
  } stat_t;

endpackage

// ===== sv/sll_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere lattice level set: controller
// Sequences axis setup, per-axis squared distances, the lattice sweep and
// the square root, issuing one command word per cycle to the datapath.
// ----------------------------------------------------------------------------
module sll_ctrl import sll_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PROD    = 4'd1;
  localparam logic [3:0] S_AXINIT  = 4'd2;
  localparam logic [3:0] S_CNT     = 4'd3;
  localparam logic [3:0] S_DIVINIT = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_SPLAT   = 4'd6;
  localparam logic [3:0] S_SQLOAD  = 4'd7;
  localparam logic [3:0] S_SQPP    = 4'd8;
  localparam logic [3:0] S_SQSTORE = 4'd9;
  localparam logic [3:0] S_VISIT   = 4'd10;
  localparam logic [3:0] S_DRAIN   = 4'd11;
  localparam logic [3:0] S_SQINIT  = 4'd12;
  localparam logic [3:0] S_SQRT    = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0]       state_r, state_nxt;
  logic [CTR_W-1:0] ctr_r, ctr_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       pp_r, pp_nxt;
  logic [IDX_W-1:0] vi_r, vi_nxt;
  logic [IDX_W-1:0] vj_r, vj_nxt;
  logic [IDX_W-1:0] vk_r, vk_nxt;

  // True when an index is the last one of a count.
  function automatic logic is_last(input logic [IDX_W-1:0] i, input logic [CNT_W-1:0] n);
    logic [CNT_W:0] ie;
    ie = {{(CNT_W - IDX_W + 1){1'b0}}, i} + 1'b1;
    return ie == {1'b0, n};
  endfunction

  assign busy = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    ctr_nxt   = ctr_r;
    axis_nxt  = axis_r;
    idx_nxt   = idx_r;
    pp_nxt    = pp_r;
    vi_nxt    = vi_r;
    vj_nxt    = vj_r;
    vk_nxt    = vk_r;
    cmd        = '0;
    cmd.axis   = axis_r;
    cmd.idx    = idx_r;
    cmd.pp_sel = pp_r;
    cmd.vi     = vi_r;
    cmd.vj     = vj_r;
    cmd.vk     = vk_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_pt = 1'b1;
          state_nxt   = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod      = 1'b1;
        cmd.best_init = 1'b1;
        axis_nxt      = AX_X;
        state_nxt     = S_AXINIT;
      end
      S_AXINIT: begin
        cmd.axis_init = 1'b1;
        ctr_nxt       = '0;
        state_nxt     = S_CNT;
      end
      S_CNT: begin
        if (ctr_r == CTR_W'(MAX_SPH - 1)) begin
          state_nxt = S_DIVINIT;
        end else begin
          cmd.cnt_step = 1'b1;
          ctr_nxt      = ctr_r + 1'b1;
        end
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        ctr_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        ctr_nxt      = ctr_r + 1'b1;
        if (ctr_r == CTR_W'(DIV_STEPS - 1)) begin
          state_nxt = S_SPLAT;
        end
      end
      S_SPLAT: begin
        cmd.sp_latch = 1'b1;
        idx_nxt      = '0;
        state_nxt    = S_SQLOAD;
      end
      S_SQLOAD: begin
        cmd.sq_load = 1'b1;
        pp_nxt      = PP_LL;
        state_nxt   = S_SQPP;
      end
      S_SQPP: begin
        cmd.sq_pp = 1'b1;
        if (pp_r == PP_HH) begin
          state_nxt = S_SQSTORE;
        end else begin
          pp_nxt = pp_r + 2'd1;
        end
      end
      S_SQSTORE: begin
        cmd.sq_store = 1'b1;
        if (is_last(idx_r, stat.n_cur)) begin
          if (axis_r == AX_Z) begin
            vi_nxt    = '0;
            vj_nxt    = '0;
            vk_nxt    = '0;
            state_nxt = S_VISIT;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_AXINIT;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SQLOAD;
        end
      end
      S_VISIT: begin
        cmd.visit = 1'b1;
        if (is_last(vk_r, stat.cnt_z)) begin
          vk_nxt = '0;
          if (is_last(vj_r, stat.cnt_y)) begin
            vj_nxt = '0;
            if (is_last(vi_r, stat.cnt_x)) begin
              ctr_nxt   = '0;
              state_nxt = S_DRAIN;
            end else begin
              vi_nxt = vi_r + 1'b1;
            end
          end else begin
            vj_nxt = vj_r + 1'b1;
          end
        end else begin
          vk_nxt = vk_r + 1'b1;
        end
      end
      S_DRAIN: begin
        ctr_nxt = ctr_r + 1'b1;
        if (ctr_r == CTR_W'(2)) begin
          state_nxt = S_SQINIT;
        end
      end
      S_SQINIT: begin
        cmd.sqrt_init = 1'b1;
        ctr_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        ctr_nxt       = ctr_r + 1'b1;
        if (ctr_r == CTR_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.out_fire = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctr_r   <= '0;
      axis_r  <= AX_X;
      idx_r   <= '0;
      pp_r    <= PP_LL;
      vi_r    <= '0;
      vj_r    <= '0;
      vk_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
      axis_r  <= axis_nxt;
      idx_r   <= idx_nxt;
      pp_r    <= pp_nxt;
      vi_r    <= vi_nxt;
      vj_r    <= vj_nxt;
      vk_r    <= vk_nxt;
    end
  end

endmodule

// ===== sv/sll_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere lattice level set: datapath
// Sphere counts, spacing divider, per-axis squared distances, the pipelined
// minimum search over the lattice and a digit-by-digit square root.
// ----------------------------------------------------------------------------
module sll_dp import sll_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output stat_t              stat,
  output logic               out_valid,
  output logic signed [31:0] out_level_value
);

  logic signed [31:0] pt_x_r, pt_y_r, pt_z_r;
  logic [PROD_W-1:0]  prod_r;
  logic signed [33:0] len_r;
  logic [ACC_W-1:0]   acc_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   cnt_r [3];
  logic [31:0]        quo_r;
  logic [CNT_W-1:0]   drem_r;
  logic               neg_r;
  logic signed [33:0] sp_r;
  logic signed [M_W-1:0] m_r;
  logic [MAG_W-1:0]   mag_r;
  logic [SUM_W-1:0]   sq_r;
  logic [SUM_W-1:0]   dist_r [3][MAX_SPH];
  logic [SUM_W-1:0]   t_r, s_r, best_r;
  logic [IDX_W-1:0]   k1_r;
  logic               v1_r, v2_r, first_r;
  logic [SUM_W-1:0]   src_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic signed [31:0] level_r;
  logic               out_valid_r;

  logic signed [31:0]    low_s, high_s, pt_s;
  logic signed [33:0]    len_nxt, len_mag, sp_val;
  logic                  len_pos;
  logic [ACC_W-1:0]      acc_nxt, lim;
  logic [CNT_W:0]        dtmp;
  logic                  dge;
  logic signed [M_W-1:0] m_half, off, ctr_pos, d, dmag, sp2;
  logic [17:0]           opa, opb;
  logic [35:0]           mprod;
  logic [SUM_W-1:0]      addend;
  logic [REM_W-1:0]      rem_sh, trial;
  logic signed [ROOT_W+1:0] diff;

  // Per-axis operand selection.
  always_comb begin
    case (cmd.axis)
      AX_X: begin
        low_s = cfg.low_x; high_s = cfg.high_x; pt_s = pt_x_r;
      end
      AX_Y: begin
        low_s = cfg.low_y; high_s = cfg.high_y; pt_s = pt_y_r;
      end
      default: begin
        low_s = cfg.low_z; high_s = cfg.high_z; pt_s = pt_z_r;
      end
    endcase
  end

  // Axis length and sphere count by repeated addition of the product.
  assign len_nxt = {{2{high_s[31]}}, high_s} - {{2{low_s[31]}}, low_s};
  assign len_pos = !len_r[33] && (len_r != '0);
  assign acc_nxt = acc_r + ACC_W'(prod_r);
  assign lim     = ACC_W'({len_r[31:0], 16'b0});

  // Restoring divider step and signed spacing.
  assign len_mag = len_r[33] ? -len_r : len_r;
  assign dtmp    = {drem_r, quo_r[31]};
  assign dge     = (dtmp >= {1'b0, n_r});
  assign sp_val  = neg_r ? -$signed({2'b0, quo_r}) : $signed({2'b0, quo_r});

  // Sphere centre and distance along the current axis.
  assign m_half  = m_r >>> 1;
  assign off     = m_half + M_W'(m_r[M_W-1] & m_r[0]);
  assign ctr_pos = {{(M_W-32){low_s[31]}}, low_s} + off;
  assign d       = {{(M_W-32){pt_s[31]}}, pt_s} - ctr_pos;
  assign dmag    = d[M_W-1] ? -d : d;
  assign sp2     = {{(M_W-35){sp_r[33]}}, sp_r, 1'b0};

  // Squaring by three narrow partial products.
  assign opa   = (cmd.pp_sel == PP_LL) ? mag_r[17:0] : {1'b0, mag_r[MAG_W-1:18]};
  assign opb   = (cmd.pp_sel == PP_HH) ? {1'b0, mag_r[MAG_W-1:18]} : mag_r[17:0];
  assign mprod = opa * opb;
  always_comb begin
    case (cmd.pp_sel)
      PP_LL:   addend = SUM_W'(mprod);
      PP_HL:   addend = SUM_W'(mprod) << 19;
      PP_HH:   addend = SUM_W'(mprod) << 36;
      default: addend = '0;
    endcase
  end

  // Square root step.
  assign rem_sh = {rem_r[REM_W-3:0], src_r[SUM_W-1:SUM_W-2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign diff   = $signed({2'b0, root_r}) - $signed((ROOT_W+2)'(cfg.radius));

  assign stat.n_cur = n_r;
  assign stat.cnt_x = cnt_r[0];
  assign stat.cnt_y = cnt_r[1];
  assign stat.cnt_z = cnt_r[2];

  assign out_valid       = out_valid_r;
  assign out_level_value = level_r;

  // Sweep pipeline control and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.visit;
      v2_r        <= v1_r;
      out_valid_r <= cmd.out_fire;
      if (cmd.best_init) begin
        first_r <= 1'b1;
      end else if (v2_r) begin
        first_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      pt_x_r <= in_point_x;
      pt_y_r <= in_point_y;
      pt_z_r <= in_point_z;
    end
    if (cmd.prod) begin
      prod_r <= {31'b0, cfg.pack} * {31'b0, cfg.radius};
    end
    if (cmd.axis_init) begin
      len_r <= len_nxt;
      acc_r <= ACC_W'(prod_r);
      n_r   <= CNT_W'(1);
    end
    if (cmd.cnt_step) begin
      acc_r <= acc_nxt;
      if (len_pos && (acc_nxt <= lim)) begin
        n_r <= n_r + 1'b1;
      end
    end
    if (cmd.div_init) begin
      quo_r  <= len_mag[31:0];
      neg_r  <= len_r[33];
      drem_r <= '0;
      cnt_r[cmd.axis] <= n_r;
    end
    if (cmd.div_step) begin
      quo_r  <= {quo_r[30:0], dge};
      drem_r <= dge ? CNT_W'(dtmp - {1'b0, n_r}) : dtmp[CNT_W-1:0];
    end
    if (cmd.sp_latch) begin
      sp_r <= sp_val;
      m_r  <= {{(M_W-34){sp_val[33]}}, sp_val};
    end
    if (cmd.sq_load) begin
      mag_r <= dmag[MAG_W-1:0];
      sq_r  <= '0;
      m_r   <= m_r + sp2;
    end
    if (cmd.sq_pp) begin
      sq_r <= sq_r + addend;
    end
    if (cmd.sq_store) begin
      dist_r[cmd.axis][cmd.idx] <= sq_r;
    end
    // Lattice sweep: two adds then the running minimum.
    t_r  <= dist_r[0][cmd.vi] + dist_r[1][cmd.vj];
    k1_r <= cmd.vk;
    s_r  <= t_r + dist_r[2][k1_r];
    if (v2_r && (first_r || (s_r < best_r))) begin
      best_r <= s_r;
    end
    if (cmd.sqrt_init) begin
      src_r  <= best_r;
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      src_r <= src_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.out_fire) begin
      if (diff > $signed((ROOT_W+2)'(32'h7FFF_FFFF))) begin
        level_r <= 32'sh7FFF_FFFF;
      end else begin
        level_r <= diff[31:0];
      end
    end
  end

endmodule

// ===== sv/sphere_lattice_level_set_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere lattice level set: top level
// Each point runs through per-axis 32-step divisions, a sweep over sphere
// centres, one per cycle, and a 36-step square root. One point at a time:
// busy stays high until the result strobe, and no new point is taken while
// it is high.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous active-low reset restores the default domain and idles the block.
// ----------------------------------------------------------------------------
module sphere_lattice_level_set_top import sll_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_point_x,
  input  logic signed [31:0]   in_point_y,
  input  logic signed [31:0]   in_point_z,
  output logic                 out_valid,
  output logic signed [31:0]   out_level_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // Configuration register file; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_x  <= 32'sd0;
      cfg_r.low_y  <= 32'sd0;
      cfg_r.low_z  <= 32'sd0;
      cfg_r.high_x <= 32'sd655360;
      cfg_r.high_y <= 32'sd655360;
      cfg_r.high_z <= 32'sd655360;
      cfg_r.radius <= 31'd65536;
      cfg_r.pack   <= 31'd262144;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_X:  cfg_r.low_x  <= cfg_wdata;
        REG_LOW_Y:  cfg_r.low_y  <= cfg_wdata;
        REG_LOW_Z:  cfg_r.low_z  <= cfg_wdata;
        REG_HIGH_X: cfg_r.high_x <= cfg_wdata;
        REG_HIGH_Y: cfg_r.high_y <= cfg_wdata;
        REG_HIGH_Z: cfg_r.high_z <= cfg_wdata;
        REG_RADIUS: cfg_r.radius <= cfg_wdata[30:0];
        REG_PACK:   cfg_r.pack   <= cfg_wdata[30:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  sll_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Arithmetic.
  sll_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg_r),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_level_value (out_level_value)
  );

endmodule

// ===== bench/sphere_lattice_level_set_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere lattice level set: testbench
// Sends query points, predicts the level value of the sphere lattice with a
// behavioural model held here, and compares every result strobe against the
// oldest prediction. Several domain, radius and packing settings are visited.
// ----------------------------------------------------------------------------
module sphere_lattice_level_set_top_tb import sll_pkg::*;;

  localparam int MAX_N      = 8;
  localparam int WDOG_LIMIT = 20000;
  localparam int TAIL       = 900;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [31:0]   in_point_x;
  logic signed [31:0]   in_point_y;
  logic signed [31:0]   in_point_z;
  logic                 out_valid;
  logic signed [31:0]   out_level_value;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  // Shadow copy of the register file.
  logic signed [31:0] dom_low [3];
  logic signed [31:0] dom_high [3];
  logic [30:0]        radius_q;
  logic [30:0]        pack_q;

  logic signed [31:0] level_queue [$];
  int                 fail_count;
  int                 idle_pct;
  int                 wdog;

  sphere_lattice_level_set_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_level_value(out_level_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Floor square root of a wide sum, bit by bit.
  function automatic logic [35:0] floor_root(logic [71:0] s);
    logic [35:0] r;
    logic [35:0] t;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      t = r | (36'd1 << b);
      if ({36'd0, t} * {36'd0, t} <= s) r = t;
    end
    return r;
  endfunction

  // Nearest lattice centre distance minus radius, saturated.
  function automatic logic signed [31:0] predict_level(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz);
    longint      pt [3];
    longint      cnt [3];
    longint      sp [3];
    longint      len;
    longint      d;
    longint      lv;
    logic [63:0] prod;
    logic [63:0] q;
    logic [71:0] best;
    logic [71:0] s;
    logic [71:0] sq [3][MAX_N];
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    prod = 64'(pack_q) * 64'(radius_q);
    for (int a = 0; a < 3; a++) begin
      len = longint'(dom_high[a]) - longint'(dom_low[a]);
      cnt[a] = 1;
      if (len > 0) begin
        if (prod == 0) cnt[a] = MAX_N;
        else begin
          q = (64'(len) << 16) / prod;
          if (q > MAX_N) q = MAX_N;
          cnt[a] = (q < 1) ? 1 : longint'(q);
        end
      end
      sp[a] = len / cnt[a];
      for (int i = 0; i < cnt[a]; i++) begin
        d = pt[a] - (longint'(dom_low[a]) + ((2 * i + 1) * sp[a]) / 2);
        if (d < 0) d = -d;
        sq[a][i] = 72'(d) * 72'(d);
      end
    end
    best = '1;
    for (int i = 0; i < cnt[0]; i++)
      for (int j = 0; j < cnt[1]; j++)
        for (int k = 0; k < cnt[2]; k++) begin
          s = sq[0][i] + sq[1][j] + sq[2][k];
          if (s < best) best = s;
        end
    lv = longint'(floor_root(best)) - longint'(radius_q);
    if (lv > 64'sd2147483647) lv = 64'sd2147483647;
    return 32'(lv);
  endfunction

  // Random stall before a transaction.
  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) @(negedge clk);
  endtask

  // Send one query point and record its expected level value.
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z);
    idle_gap();
    while (busy) @(negedge clk);
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    start <= 1'b1;
    // Busy is low here, so the next rising edge takes the point.
    @(negedge clk);
    start <= 1'b0;
    level_queue.insert(level_queue.size(), predict_level(x, y, z));
  endtask

  // Wait until every result has arrived, then let the block settle.
  task automatic drain();
    while (level_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register and mirror it in the shadow copy; the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    drain();
    idle_gap();
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LOW_X:  dom_low[0] = val;
      REG_LOW_Y:  dom_low[1] = val;
      REG_LOW_Z:  dom_low[2] = val;
      REG_HIGH_X: dom_high[0] = val;
      REG_HIGH_Y: dom_high[1] = val;
      REG_HIGH_Z: dom_high[2] = val;
      REG_RADIUS: radius_q = val[30:0];
      REG_PACK:   pack_q = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_domain(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
      logic [31:0] hx, logic [31:0] hy, logic [31:0] hz, logic [31:0] rad,
      logic [31:0] pk);
    drain();
    write_reg(REG_LOW_X, lx);
    write_reg(REG_LOW_Y, ly);
    write_reg(REG_LOW_Z, lz);
    write_reg(REG_HIGH_X, hx);
    write_reg(REG_HIGH_Y, hy);
    write_reg(REG_HIGH_Z, hz);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_PACK, pk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * 655360)) - 65536);
      2: return 32'($signed($urandom_range(131072)) - 65536);
      default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  // Field extremes and points in and around the default domain.
  task automatic test_directed_points();
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_point(0, 0, 0);
    send_point(32'sh0001_4000, 32'sh0001_4000, 32'sh0001_4000);
    send_point(32'sh0001_4000, 32'sh0002_4000, 32'sh0001_4000);
    send_point(-1, -1, -1);
    send_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F);
  endtask

  // Special domains: inverted and empty axes, zero radius, zero packing,
  // saturated counts, widest domain, far points and unknown indexes.
  task automatic test_special_settings();
    set_domain(32'sh000A_0000, 32'sh0005_0000, 0, 0, 32'sh0005_0000,
               32'sh0004_0000, 32'h0000_8000, 32'h0004_0000);
    send_point(0, 32'sh0005_0000, 32'sh0002_0000);
    send_point(32'sh0007_0000, 32'sh0005_0000, 0);
    set_domain(0, 0, 0, 32'sh0008_0000, 32'sh0008_0000, 32'sh0008_0000,
               0, 32'h0004_0000);
    send_point(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
    send_point(32'sh0003_0000, 0, 32'sh0007_0000);
    write_reg(REG_RADIUS, 32'h0001_0000);
    write_reg(REG_PACK, 0);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    set_domain(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(0, 0, 0);
    write_reg(REG_RADIUS, 1);
    write_reg(REG_PACK, 1);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678);
    set_domain(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
               32'h0000_0001, 32'hFFFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    // Indexes past the last register are ignored by the block.
    write_reg(4'd8, 32'hDEAD_BEEF);
    write_reg(4'd15, 32'h0000_0000);
    send_point(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
  endtask

  // Random settings, each followed by a batch of random points.
  task automatic test_random_points();
    logic [31:0] lo [3];
    logic [31:0] hi [3];
    for (int phase = 0; phase < 14; phase++) begin
      for (int a = 0; a < 3; a++) begin
        if ($urandom_range(5) == 0) begin
          lo[a] = $urandom();
          hi[a] = $urandom();
        end else begin
          lo[a] = 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
          hi[a] = lo[a] + $urandom_range(12 * 65536);
        end
      end
      set_domain(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                 $urandom_range(3) == 0 ? $urandom() : $urandom_range(3 * 65536),
                 $urandom_range(3) == 0 ? $urandom() : $urandom_range(8 * 65536));
      // One quiet phase with no stalls at all.
      idle_pct = (phase == 6) ? 0 : 18;
      for (int n = 0; n < 48; n++) send_point(rand_coord(), rand_coord(), rand_coord());
    end
    idle_pct = 18;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (level_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d",
                 $realtime, out_level_value);
        fail_count++;
      end else begin
        logic signed [31:0] want;
        want = level_queue.pop_front();
        if (out_level_value !== want) begin
          $display("%0t: level_value mismatch, expected %0d, actual %0d",
                   $realtime, want, out_level_value);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      wdog <= 0;
    else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("sphere_lattice_level_set_top_tb failed");
        $finish;
      end
    end
  end

  initial begin
    fail_count = 0;
    idle_pct   = 18;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    for (int a = 0; a < 3; a++) begin
      dom_low[a]  = 0;
      dom_high[a] = 32'sh000A_0000;
    end
    radius_q = 31'h0001_0000;
    pack_q   = 31'h0004_0000;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_points();
    test_special_settings();
    test_random_points();

    drain();
    repeat (TAIL) @(negedge clk);
    if (fail_count == 0 && level_queue.size() == 0)
      $display("sphere_lattice_level_set_top_tb passed");
    else
      $display("sphere_lattice_level_set_top_tb failed");
    $finish;
  end

endmodule
